>>> hdl/ssr_pkg.sv
// Shared types, constants and helpers for the string search/replace block.
// No dependencies; compiled first.
package ssr_pkg;

   localparam int PATTERN_MAX_DEF = 8;
   localparam int BYTE_W          = 8;
   localparam int COUNT_W         = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int LEN_W           = 4;
   localparam int REP_MAX         = 8;
   localparam int REP_IDX_W       = 3;

   localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES      = 3'd0,
      CSR_PATTERN_LENGTH     = 3'd1,
      CSR_REPLACEMENT_BYTES  = 3'd2,
      CSR_REPLACEMENT_LENGTH = 3'd3,
      CSR_CASE_INSENSITIVE   = 3'd4
   } csr_index_type;

   typedef enum logic {
      ST_RUN,
      ST_FLUSH
   } run_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               run_last;
      logic               text_done;
      logic [COUNT_W-1:0] match_count;
   } rsp_item_type;

   // ASCII lower-case fold, active only in case-insensitive mode
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic ci);
      logic [BYTE_W-1:0] r;
      r = c;
      if (ci && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
         r = c + ASCII_CASE_OFS;
      end
      return r;
   endfunction

endpackage

>>> hdl/ssr_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on ssr_pkg.
interface ssr_req_if;
   import ssr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ssr_rsp_if;
   import ssr_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               byte_valid;
   logic               run_last;
   logic               text_done;
   logic [COUNT_W-1:0] match_count;

   modport source (output valid, out_byte, byte_valid, run_last, text_done, match_count,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, run_last, text_done, match_count,
                   output ready);
endinterface

>>> hdl/ssr_cell.sv
// One window cell: holds a pending byte, shifts toward the head, and compares
// against its own pattern byte and the one before it. Depends on ssr_pkg.
module ssr_cell (
   input  logic                      clock,
   input  logic                      shift,
   input  logic                      load,
   input  logic [ssr_pkg::BYTE_W-1:0] load_byte,
   input  logic [ssr_pkg::BYTE_W-1:0] next_byte,
   input  logic [ssr_pkg::BYTE_W-1:0] pat_here,
   input  logic [ssr_pkg::BYTE_W-1:0] pat_prev,
   output logic [ssr_pkg::BYTE_W-1:0] byte_q,
   output logic                      eq,
   output logic                      eq_prev
);
   import ssr_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // load wins: the appended byte lands where the shift would leave garbage
   always_comb begin
      byte_in = byte_ff;
      if (load) begin
         byte_in = load_byte;
      end else if (shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_q  = byte_ff;
   assign eq      = (byte_ff == pat_here);
   assign eq_prev = (byte_ff == pat_prev);

endmodule

>>> hdl/ssr_out_buf.sv
// Two-entry response queue between the cell row and the response channel.
// Depends on ssr_pkg and ssr_if.
module ssr_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssr_pkg::rsp_item_type push_item,
   output logic                  space,
   ssr_rsp_if.source             rsp_chan
);
   import ssr_pkg::*;

   rsp_item_type item_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;
   rsp_item_type head;

   assign pop   = rsp_chan.valid && rsp_chan.ready;
   assign space = (count_ff != 2'd2);
   assign head  = item_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.out_byte    = head.out_byte;
   assign rsp_chan.byte_valid  = head.byte_valid;
   assign rsp_chan.run_last    = head.run_last;
   assign rsp_chan.text_done   = head.text_done;
   assign rsp_chan.match_count = head.match_count;

endmodule

>>> hdl/string_search_replace.sv
// Streaming search and replace: top level with control, cell row and queue.
// Depends on ssr_pkg, ssr_if, ssr_cell and ssr_out_buf.
//
// Usage: text bytes enter on req_chan, one per request; end_of_text marks the
// last byte of a text. Rewritten bytes leave on rsp_chan: pass-through bytes,
// replacement bytes in place of each leftmost non-overlapping match, and after
// end_of_text the held bytes followed by a status item with match_count.
// run_last flags the last response caused by a request. Registers are written
// through csr_we/csr_index/csr_wdata; the user must write them only while no
// text is in flight, and the block itself does not enforce this.
// Throughput: one request per cycle while bytes pass through or extend a
// partial match and the queue has space. A full match emits the replacement
// bytes in turn, taking a request with the last (at once if it is empty);
// bytes released from a broken partial match and, at end of text, held bytes
// then the status item leave in turn from the single head-of-window output
// per cycle. A taken request is written into the window, then its first
// response is queued. Reset clears the window, the match count and the
// registers (pattern length one). A stalled receiver fills the two-entry
// response queue, after which requests are held off until it drains.
module string_search_replace #(
   parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   ssr_req_if.sink                       req_chan,
   ssr_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ssr_pkg::*;

   localparam int FW = $clog2(PATTERN_MAX + 1);

   // configuration
   logic [CSR_DATA_W-1:0] pat_ff, rep_ff;
   logic [FW-1:0]         plen_ff;
   logic [LEN_W-1:0]      rlen_ff;
   logic                  ci_ff;
   logic [LEN_W-1:0]      plen_wr, rlen_wr;
   logic [FW-1:0]         plen_eff;

   // control state
   run_state_type         state_ff, state_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  eot_ff, eot_in;
   logic [REP_IDX_W-1:0]  rep_idx_ff, rep_idx_in;
   logic                  busy_ff, busy_in;

   // cell row
   logic [BYTE_W-1:0]     win_byte [PATTERN_MAX];
   logic [BYTE_W-1:0]     nb_byte  [PATTERN_MAX];
   logic [BYTE_W-1:0]     pat_fold [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] eq, eq_prev, cell_load;
   logic                  shift;
   logic [BYTE_W-1:0]     new_byte;

   // decisions
   logic [FW-1:0]         cmp_len, fill_dec, cmp_sh, fill_mid;
   logic                  ok, ok_sh, full, rep_last;
   logic                  push, take_ok, settled, repl_done, rep_adv, flush_done;
   logic                  accept, out_space;
   rsp_item_type          push_item;
   logic [BYTE_W-1:0]     rep_byte;

   // ---------------- configuration ----------------
   assign plen_wr = csr_wdata[LEN_W-1:0];
   assign rlen_wr = csr_wdata[LEN_W-1:0];

   always_comb begin
      if (plen_wr == '0) begin
         plen_eff = FW'(1);
      end else if (plen_wr > LEN_W'(PATTERN_MAX)) begin
         plen_eff = FW'(PATTERN_MAX);
      end else begin
         plen_eff = plen_wr[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= FW'(1);
         rep_ff  <= '0;
         rlen_ff <= '0;
         ci_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      pat_ff  <= csr_wdata;
            CSR_PATTERN_LENGTH:     plen_ff <= plen_eff;
            CSR_REPLACEMENT_BYTES:  rep_ff  <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: rlen_ff <= (rlen_wr > LEN_W'(REP_MAX)) ?
                                               LEN_W'(REP_MAX) : rlen_wr;
            CSR_CASE_INSENSITIVE:   ci_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- cell row ----------------
   assign new_byte = fold_byte(req_chan.text_byte, ci_ff);

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      assign pat_fold[k]  = fold_byte(pat_ff[8*k +: 8], ci_ff);
      assign cell_load[k] = accept && (fill_mid == FW'(k));
      if (k == PATTERN_MAX - 1) begin : g_tail
         assign nb_byte[k] = '0;
      end else begin : g_body
         assign nb_byte[k] = win_byte[k+1];
      end
      ssr_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .load      (cell_load[k]),
         .load_byte (new_byte),
         .next_byte (nb_byte[k]),
         .pat_here  (pat_fold[k]),
         .pat_prev  (pat_fold[(k == 0) ? 0 : k-1]),
         .byte_q    (win_byte[k]),
         .eq        (eq[k]),
         .eq_prev   (eq_prev[k])
      );
   end

   // prefix check now, and after dropping the head byte
   always_comb begin
      cmp_len  = (fill_ff < plen_ff) ? fill_ff : plen_ff;
      fill_dec = fill_ff - FW'(1);
      cmp_sh   = (fill_dec < plen_ff) ? fill_dec : plen_ff;
      ok       = 1'b1;
      ok_sh    = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (FW'(k) < cmp_len && !eq[k]) begin
            ok = 1'b0;
         end
         if (k > 0 && FW'(k-1) < cmp_sh && !eq_prev[k]) begin
            ok_sh = 1'b0;
         end
      end
      full = ok && (fill_ff >= plen_ff);
   end

   assign rep_last = ({1'b0, rep_idx_ff} == rlen_ff - LEN_W'(1));
   assign rep_byte = fold_byte(rep_ff[{rep_idx_ff, 3'b000} +: 8], ci_ff);

   // ---------------- control outputs ----------------
   always_comb begin
      push       = 1'b0;
      push_item  = '0;
      shift      = 1'b0;
      fill_mid   = fill_ff;
      settled    = 1'b0;
      repl_done  = 1'b0;
      rep_adv    = 1'b0;
      flush_done = 1'b0;
      case (state_ff)
         ST_RUN: begin
            // held bytes are rescanned only once a new request has landed
            if (!busy_ff) begin
               settled = 1'b1;
            end else if (full) begin
               if (rlen_ff == '0) begin
                  repl_done = 1'b1;
               end else if (out_space) begin
                  push                 = 1'b1;
                  push_item.out_byte   = rep_byte;
                  push_item.byte_valid = 1'b1;
                  push_item.run_last   = rep_last && !eot_ff;
                  repl_done            = rep_last;
                  rep_adv              = !rep_last;
               end
               if (repl_done) begin
                  fill_mid = '0;
                  settled  = 1'b1;
               end
            end else if (!ok) begin
               if (out_space) begin
                  push                 = 1'b1;
                  push_item.out_byte   = win_byte[0];
                  push_item.byte_valid = 1'b1;
                  push_item.run_last   = ok_sh && !eot_ff;
                  shift                = 1'b1;
                  fill_mid             = fill_dec;
                  settled              = ok_sh;
               end
            end else begin
               settled = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (out_space) begin
               push = 1'b1;
               if (fill_ff != '0) begin
                  push_item.out_byte   = win_byte[0];
                  push_item.byte_valid = 1'b1;
                  shift                = 1'b1;
                  fill_mid             = fill_dec;
               end else begin
                  push_item.run_last    = 1'b1;
                  push_item.text_done   = 1'b1;
                  push_item.match_count = count_ff;
                  flush_done            = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign take_ok        = (state_ff == ST_RUN) && settled && !eot_ff;
   assign req_chan.ready = take_ok;
   assign accept         = take_ok && req_chan.valid;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (eot_ff && settled) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (flush_done) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      fill_in    = fill_mid + FW'(accept);
      count_in   = count_ff;
      eot_in     = eot_ff;
      rep_idx_in = rep_idx_ff;
      busy_in    = busy_ff;
      if (settled) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (flush_done) begin
         fill_in  = '0;
         count_in = '0;
         eot_in   = 1'b0;
      end
      // shorter pattern drops a window that can no longer be a proper prefix
      if (csr_we && csr_index == CSR_PATTERN_LENGTH && fill_ff >= plen_eff) begin
         fill_in = '0;
      end
      if (repl_done && count_ff != '1) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (accept) begin
         eot_in = req_chan.end_of_text;
      end
      if (repl_done) begin
         rep_idx_in = '0;
      end else if (rep_adv) begin
         rep_idx_in = rep_idx_ff + REP_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         fill_ff    <= '0;
         count_ff   <= '0;
         eot_ff     <= 1'b0;
         rep_idx_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         eot_ff     <= eot_in;
         rep_idx_ff <= rep_idx_in;
         busy_ff    <= busy_in;
      end
   end

   // ---------------- response queue ----------------
   ssr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (out_space),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> bench/tb.sv
// Self-checking testbench for string_search_replace: directed table, then random phases
// with random register settings and a long receiver hold-off.
// Depends on ssr_pkg, ssr_if and the string_search_replace RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssr_pkg::*;

   typedef logic [BYTE_W-1:0] octet_type;

   // one row of the directed table: either a register write or a text byte,
   // optionally with its responses typed in
   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      octet_type             text;
      logic                  eot;
      logic                  known;
      logic [1:0]            known_n;
      rsp_item_type          k0;
      rsp_item_type          k1;
   } stim_row_type;

   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int LONG_HOLD       = 150;
   localparam int HOLD_AFTER      = 60;
   localparam int MAX_PRINTED     = 40;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ssr_req_if req_chan ();
   ssr_rsp_if rsp_chan ();

   string_search_replace dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // search/replace predictor state
   logic [63:0]        pat_bytes;
   logic [3:0]         pat_len;
   logic [63:0]        rep_bytes;
   logic [3:0]         rep_len;
   logic               fold_ci;
   octet_type          held [8];
   int                 held_count;
   logic [COUNT_W-1:0] match_total;

   rsp_item_type step_out [$];
   rsp_item_type pending [$];

   int  mismatches = 0;
   int  requests_sent = 0;
   int  responses_seen = 0;
   int  texts_done = 0;
   int  stalled = 0;
   bit  calm = 1'b0;

   function automatic octet_type to_lower(input octet_type c);
      if (fold_ci && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c + ASCII_CASE_OFS;
      return c;
   endfunction

   function automatic int eff_pattern_len();
      int n;
      n = int'(pat_len);
      if (n == 0) n = 1;
      if (n > PATTERN_MAX_DEF) n = PATTERN_MAX_DEF;
      return n;
   endfunction

   function automatic void emit(input octet_type b, input logic v, input logic d,
                                input logic [COUNT_W-1:0] c);
      rsp_item_type r;
      r.out_byte    = b;
      r.byte_valid  = v;
      r.run_last    = 1'b0;
      r.text_done   = d;
      r.match_count = c;
      step_out.push_back(r);
   endfunction

   function automatic void drop_front(input int n);
      for (int k = 0; k + n < held_count; k++) held[k] = held[k + n];
      held_count -= n;
   endfunction

   // responses for one text byte, leftmost non-overlapping matching
   function automatic void search_step(input octet_type b, input logic eot);
      int   plen;
      int   cmp;
      int   rlen;
      logic same;
      step_out.delete();
      plen = eff_pattern_len();
      if (held_count < 8) begin
         held[held_count] = to_lower(b);
         held_count++;
      end
      while (held_count > 0) begin
         cmp = (held_count < plen) ? held_count : plen;
         same = 1'b1;
         for (int k = 0; k < cmp; k++) begin
            if (held[k] != to_lower(pat_bytes[8*k +: 8])) same = 1'b0;
         end
         if (same && held_count >= plen) begin
            rlen = (rep_len > 4'd8) ? 8 : int'(rep_len);
            for (int k = 0; k < rlen; k++) emit(to_lower(rep_bytes[8*k +: 8]), 1'b1, 1'b0, '0);
            if (match_total != COUNT_MAX) match_total++;
            drop_front(plen);
         end else if (same) begin
            break;
         end else begin
            emit(held[0], 1'b1, 1'b0, '0);
            drop_front(1);
         end
      end
      if (eot) begin
         for (int k = 0; k < held_count; k++) emit(held[k], 1'b1, 1'b0, '0);
         emit('0, 1'b0, 1'b1, match_total);
         held_count  = 0;
         match_total = '0;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic octet_type random_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return ASCII_UPPER_A + octet_type'($urandom_range(0, 25));
      if (r < 7) return 8'h61 + octet_type'($urandom_range(0, 25));
      return octet_type'($urandom_range(0, 255));
   endfunction

   function automatic octet_type noise_byte(input int plen);
      if ($urandom_range(0, 1) == 0) return pat_bytes[8*$urandom_range(0, plen - 1) +: 8];
      return random_char();
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type idx,
                                            input logic [CSR_DATA_W-1:0] d);
      stim_row_type r;
      r = '0;
      r.is_csr   = 1'b1;
      r.csr_idx  = idx;
      r.csr_data = d;
      return r;
   endfunction

   function automatic stim_row_type text_row(input octet_type b, input logic e);
      stim_row_type r;
      r = '0;
      r.text = b;
      r.eot  = e;
      return r;
   endfunction

   function automatic stim_row_type known_row(input octet_type b, input logic e, input int n,
                                              input rsp_item_type k0,
                                              input rsp_item_type k1);
      stim_row_type r;
      r = text_row(b, e);
      r.known   = 1'b1;
      r.known_n = n[1:0];
      r.k0      = k0;
      r.k1      = k1;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got_v,
                                input logic [63:0] want_v);
      if (mismatches < MAX_PRINTED)
         $display("ERROR response %0d %s: got 0x%0h, want 0x%0h",
                  responses_seen, what, got_v, want_v);
      mismatches++;
   endtask

   // entered and left at a falling edge
   task automatic send_text(input octet_type b, input logic e, input int n_known,
                            input rsp_item_type k0, input rsp_item_type k1);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= b;
      req_chan.end_of_text <= e;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      search_step(b, e);
      if (n_known >= 0) begin
         step_out.delete();
         if (n_known >= 1) step_out.push_back(k0);
         if (n_known >= 2) step_out.push_back(k1);
      end
      foreach (step_out[i]) pending.push_back(step_out[i]);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      case (idx)
         CSR_PATTERN_BYTES: pat_bytes = d;
         CSR_PATTERN_LENGTH: begin
            pat_len = d[LEN_W-1:0];
            // held bytes that already reach the new length are dropped
            if (held_count >= eff_pattern_len()) held_count = 0;
         end
         CSR_REPLACEMENT_BYTES:  rep_bytes = d;
         CSR_REPLACEMENT_LENGTH: rep_len = d[LEN_W-1:0];
         CSR_CASE_INSENSITIVE:   fold_ci = d[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every expected response is out and the pipe is quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(input bit close_text);
      octet_type             chunk [$];
      octet_type             c;
      int                    plen;
      int                    pick;
      int                    m;
      int                    sent;
      logic                  e;
      logic [CSR_DATA_W-1:0] word;
      settle();
      for (int k = 0; k < 8; k++) word[8*k +: 8] = random_char();
      csr_write(CSR_PATTERN_BYTES, word);
      if ($urandom_range(0, 1) == 0) begin
         word = {$urandom(), $urandom()};
      end else begin
         for (int k = 0; k < 8; k++) word[8*k +: 8] = random_char();
      end
      csr_write(CSR_REPLACEMENT_BYTES, word);
      csr_write(CSR_REPLACEMENT_LENGTH, 64'($urandom_range(0, 15)));
      csr_write(CSR_CASE_INSENSITIVE, 64'($urandom_range(0, 1)));
      csr_write(CSR_PATTERN_LENGTH, 64'($urandom_range(0, 15)));
      plen = eff_pattern_len();
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         chunk.delete();
         pick = $urandom_range(0, 99);
         // mostly whole pattern copies, then broken prefixes, then noise
         m = (pick < 55) ? plen : (pick < 80) ? $urandom_range(0, plen - 1) : 0;
         for (int k = 0; k < m; k++) begin
            c = pat_bytes[8*k +: 8];
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A
                && $urandom_range(0, 99) < (fold_ci ? 50 : 8))
               c = c ^ 8'h20;
            chunk.push_back(c);
         end
         if (pick >= 55) begin
            repeat ($urandom_range(1, (pick < 80) ? 1 : 4)) chunk.push_back(noise_byte(plen));
         end
         foreach (chunk[i]) begin
            if (sent == ITEMS_PER_PHASE) break;
            sent++;
            e = (sent == ITEMS_PER_PHASE) ? close_text : ($urandom_range(0, 29) == 0);
            send_text(chunk[i], e, -1, '0, '0);
         end
      end
   endtask

   initial begin : calm_stretches
      forever begin
         repeat ($urandom_range(40, 300)) @(posedge clock);
         calm = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : response_ready
      int hold;
      bit pressed;
      hold = 0;
      pressed = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off while requests are offered, so the block backs up
         if (!pressed && responses_seen >= HOLD_AFTER && req_chan.valid) begin
            pressed = 1'b1;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : response_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.out_byte    = rsp_chan.out_byte;
         got.byte_valid  = rsp_chan.byte_valid;
         got.run_last    = rsp_chan.run_last;
         got.text_done   = rsp_chan.text_done;
         got.match_count = rsp_chan.match_count;
         responses_seen++;
         if (got.text_done === 1'b1) texts_done++;
         if (pending.size() == 0) begin
            flag_mismatch("unexpected response", got, '0);
         end else begin
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte)
               flag_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid !== want.byte_valid)
               flag_mismatch("byte_valid", got.byte_valid, want.byte_valid);
            if (got.run_last !== want.run_last)
               flag_mismatch("run_last", got.run_last, want.run_last);
            if (got.text_done !== want.text_done)
               flag_mismatch("text_done", got.text_done, want.text_done);
            if (got.match_count !== want.match_count)
               flag_mismatch("match_count", got.match_count, want.match_count);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stalled = 0;
      else
         stalled++;
      if (stalled >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                  stalled, pending.size());
         $display("string_search_replace regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type rows [$];
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.text_byte   <= '0;
      req_chan.end_of_text <= 1'b0;
      pat_bytes   = '0;
      pat_len     = 4'd1;
      rep_bytes   = '0;
      rep_len     = '0;
      fold_ci     = 1'b0;
      held_count  = 0;
      match_total = '0;
      for (int k = 0; k < 8; k++) held[k] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset values: pattern 0x00 of length one, empty replacement
      rows.push_back(known_row(8'hFF, 1'b1, 2, rsp_item_type'{8'hFF, 1'b1, 1'b0, 1'b0, 16'd0},
                               rsp_item_type'{8'h00, 1'b0, 1'b1, 1'b1, 16'd0}));
      // zero byte matches and is deleted
      rows.push_back(known_row(8'h00, 1'b1, 1, rsp_item_type'{8'h00, 1'b0, 1'b1, 1'b1, 16'd1},
                               '0));
      // pattern "AbC", eight-byte mixed-case replacement
      rows.push_back(csr_row(CSR_PATTERN_BYTES, 64'h0000_0000_0043_6241));
      rows.push_back(csr_row(CSR_PATTERN_LENGTH, 64'd3));
      rows.push_back(csr_row(CSR_REPLACEMENT_BYTES, 64'h4142_4344_7A79_5958));
      rows.push_back(csr_row(CSR_REPLACEMENT_LENGTH, 64'd8));
      rows.push_back(text_row(8'h41, 1'b0));
      rows.push_back(text_row(8'h62, 1'b0));
      rows.push_back(text_row(8'h43, 1'b0));
      rows.push_back(text_row(8'h41, 1'b0));
      rows.push_back(text_row(8'h62, 1'b0));
      rows.push_back(text_row(8'h78, 1'b0));
      rows.push_back(text_row(8'h61, 1'b1));
      // case folding; shortening the pattern drops the held pair
      rows.push_back(csr_row(CSR_CASE_INSENSITIVE, 64'd1));
      rows.push_back(text_row(8'h61, 1'b0));
      rows.push_back(text_row(8'h42, 1'b0));
      rows.push_back(csr_row(CSR_PATTERN_LENGTH, 64'd2));
      rows.push_back(text_row(8'h7A, 1'b1));
      // held byte survives a replacement length change, length clamps to eight
      rows.push_back(text_row(8'h41, 1'b0));
      rows.push_back(csr_row(CSR_REPLACEMENT_LENGTH, 64'd15));
      rows.push_back(text_row(8'h42, 1'b1));
      // zero pattern length acts as one
      rows.push_back(csr_row(CSR_PATTERN_LENGTH, 64'd0));
      rows.push_back(text_row(8'h61, 1'b0));
      rows.push_back(text_row(8'h80, 1'b0));
      rows.push_back(text_row(8'h41, 1'b1));
      // oversize pattern length clamps to the window, match is deleted
      rows.push_back(csr_row(CSR_PATTERN_BYTES, '1));
      rows.push_back(csr_row(CSR_PATTERN_LENGTH, 64'd15));
      rows.push_back(csr_row(CSR_REPLACEMENT_LENGTH, 64'd0));
      rows.push_back(csr_row(CSR_CASE_INSENSITIVE, 64'd0));
      for (int k = 0; k < 8; k++) rows.push_back(text_row(8'hFF, k == 7));

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            if (i == 0 || !rows[i - 1].is_csr) settle();
            csr_write(csr_index_type'(rows[i].csr_idx), rows[i].csr_data);
         end else begin
            send_text(rows[i].text, rows[i].eot, rows[i].known ? int'(rows[i].known_n) : -1,
                      rows[i].k0, rows[i].k1);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) random_phase($urandom_range(0, 3) != 0);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d text bytes sent, %0d responses checked, %0d texts closed, %0d mismatches",
               requests_sent, responses_seen, texts_done, mismatches);
      $display("random register settings over %0d phases, held text across writes, long stall",
               RANDOM_PHASES);
      if (mismatches == 0 && pending.size() == 0)
         $display("string_search_replace regression: pass");
      else
         $display("string_search_replace regression: fail");
      $finish;
   end

endmodule
